// File: src/prd_pkg.sv
// prd_pkg: shared types, constants and helpers of the PAM3 receive decoder
// depends on nothing; used by every module under src but prd_fifo
`default_nettype none

package prd_pkg;

   localparam int unsigned SAMPLE_W = 12;
   localparam int unsigned SCR_W    = 33;
   localparam int unsigned ADDR_W   = 5;
   localparam int unsigned DATA_W   = 32;

   // register indexes on the csr port (byte address = 4 * index)
   localparam logic [2:0] REG_MASTER_MODE = 3'd0;
   localparam logic [2:0] REG_UPPER_CUT_I = 3'd1;
   localparam logic [2:0] REG_LOWER_CUT_I = 3'd2;
   localparam logic [2:0] REG_UPPER_CUT_Q = 3'd3;
   localparam logic [2:0] REG_LOWER_CUT_Q = 3'd4;

   // reset values of the cut registers
   localparam logic signed [SAMPLE_W-1:0] CUT_UPPER_RST = 12'sd819;
   localparam logic signed [SAMPLE_W-1:0] CUT_LOWER_RST = -12'sd819;

   // preamble byte sent after an ssd
   localparam logic [7:0] PREAMBLE_BYTE = 8'h55;

   // result event codes
   localparam logic [1:0] EV_DATA      = 2'd0;
   localparam logic [1:0] EV_END_GOOD  = 2'd1;
   localparam logic [1:0] EV_END_ERROR = 2'd2;
   localparam logic [1:0] EV_ABORT     = 2'd3;

   // sliced ternary level
   typedef enum logic [1:0] {
      TRIT_ZERO = 2'd0,
      TRIT_POS  = 2'd1,
      TRIT_NEG  = 2'd2
   } trit_type;

   typedef struct packed {
      trit_type ci;
      trit_type cq;
   } symbol_type;

   typedef struct packed {
      logic [1:0] event_kind;
      logic [7:0] data_byte;
      logic [1:0] spare_bits;
      logic       is_locked;
   } result_type;

   // slicer thresholds and scrambler mode
   typedef struct packed {
      logic                       master_mode;
      logic signed [SAMPLE_W-1:0] upper_cut_i;
      logic signed [SAMPLE_W-1:0] lower_cut_i;
      logic signed [SAMPLE_W-1:0] upper_cut_q;
      logic signed [SAMPLE_W-1:0] lower_cut_q;
   } config_type;

   // 3b2t: ternary pair back to three data bits
   function automatic logic [2:0] pair_to_bits(symbol_type sym);
      logic [2:0] bits;
      bits = 3'd0;
      unique case (sym.ci)
         TRIT_NEG: begin
            unique case (sym.cq)
               TRIT_NEG:  bits = 3'd0;
               TRIT_ZERO: bits = 3'd1;
               TRIT_POS:  bits = 3'd2;
               default:   bits = 3'd0;
            endcase
         end
         TRIT_ZERO: bits = (sym.cq == TRIT_NEG) ? 3'd3 : 3'd4;
         TRIT_POS: begin
            unique case (sym.cq)
               TRIT_NEG:  bits = 3'd5;
               TRIT_ZERO: bits = 3'd6;
               TRIT_POS:  bits = 3'd7;
               default:   bits = 3'd0;
            endcase
         end
         default: bits = 3'd0;
      endcase
      return bits;
   endfunction

endpackage

`default_nettype wire

// File: src/prd_fifo.sv
// prd_fifo: small first-in first-out queue of any packed item type
// depends on nothing
`default_nettype none

module prd_fifo #(
   parameter type         item_type = logic [7:0],
   parameter int unsigned DEPTH     = 2
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     wr_en,
   input  item_type      wr_data,
   output logic          is_full,
   input  wire logic     rd_en,
   output item_type      rd_data,
   output logic          is_empty
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   item_type         mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_wr, do_rd;

   assign is_full  = (count_ff == FULL_CNT);
   assign is_empty = (count_ff == '0);
   assign rd_data  = mem_ff[rd_ptr_ff];
   assign do_wr    = wr_en && !is_full;
   assign do_rd    = rd_en && !is_empty;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset
   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

// File: src/prd_slicer.sv
// prd_slicer: front end, slices an i/q sample pair to a ternary symbol
// depends on prd_pkg
`default_nettype none

module prd_slicer (
   input  wire logic signed [prd_pkg::SAMPLE_W-1:0] sample_i,
   input  wire logic signed [prd_pkg::SAMPLE_W-1:0] sample_q,
   input  prd_pkg::config_type                      cfg,
   output prd_pkg::symbol_type                      sym
);

   // in-phase and quadrature levels
   always_comb begin
      if (sample_i > cfg.upper_cut_i) begin
         sym.ci = prd_pkg::TRIT_POS;
      end else if (sample_i < cfg.lower_cut_i) begin
         sym.ci = prd_pkg::TRIT_NEG;
      end else begin
         sym.ci = prd_pkg::TRIT_ZERO;
      end
      if (sample_q > cfg.upper_cut_q) begin
         sym.cq = prd_pkg::TRIT_POS;
      end else if (sample_q < cfg.lower_cut_q) begin
         sym.cq = prd_pkg::TRIT_NEG;
      end else begin
         sym.cq = prd_pkg::TRIT_ZERO;
      end
   end

endmodule

`default_nettype wire

// File: src/prd_decoder.sv
// prd_decoder: back end, descrambler lock, ssd/esd framing and byte packing
// depends on prd_pkg
`default_nettype none

module prd_decoder #(
   parameter int unsigned LOCK_IDLES          = 256,
   parameter int unsigned UNLOCK_ERRORS       = 16,
   parameter int unsigned ERROR_CLEAR_SYMBOLS = 1024
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          master_mode,
   input  wire logic          sym_valid,
   input  prd_pkg::symbol_type sym,
   output logic               sym_take,
   input  wire logic          res_full,
   output logic               res_push,
   output prd_pkg::result_type res
);

   localparam int unsigned MW = $clog2(LOCK_IDLES + 2);
   localparam int unsigned EW = $clog2(UNLOCK_ERRORS + 2);
   localparam int unsigned CW = $clog2(ERROR_CLEAR_SYMBOLS + 2);
   localparam logic [MW-1:0] MATCH_LIM = MW'(LOCK_IDLES);
   localparam logic [EW-1:0] ERROR_LIM = EW'(UNLOCK_ERRORS);
   localparam logic [CW-1:0] CLEAN_LIM = CW'(ERROR_CLEAR_SYMBOLS);

   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_SSD1 = 3'd1,
      PH_SSD2 = 3'd2,
      PH_DATA = 3'd3,
      PH_ESD1 = 3'd4,
      PH_ESD2 = 3'd5
   } phase_type;

   phase_type                 phase_ff, phase_in;
   logic [prd_pkg::SCR_W-1:0] scr_ff, scr_in;
   logic [5:0]                acc_ff, acc_in;
   logic [1:0]                bcnt_ff, bcnt_in;
   logic [3:0]                low_ff, low_in;
   logic                      expect_low_ff, expect_low_in;
   logic                      lock_ff, lock_in;
   logic [MW-1:0]             match_ff, match_in;
   logic [EW-1:0]             err_ff, err_in;
   logic [CW-1:0]             clean_ff, clean_in;

   logic                      fb, zz, expect_bit, emit;
   logic [prd_pkg::SCR_W-1:0] scr_step;
   logic [2:0]                key, sd, bsum;
   logic [5:0]                acc_or;
   logic [3:0]                nib;
   prd_pkg::result_type       res_c;

   assign sym_take = sym_valid && !res_full;
   assign res_push = sym_take && emit;
   assign res      = res_c;

   assign fb       = scr_ff[32] ^ (master_mode ? scr_ff[12] : scr_ff[19]);
   assign scr_step = {scr_ff[prd_pkg::SCR_W-2:0], fb};
   assign zz       = (sym.ci == prd_pkg::TRIT_ZERO) && (sym.cq == prd_pkg::TRIT_ZERO);

   // expected scrambler bit for an idle symbol
   assign expect_bit = ((sym.ci == prd_pkg::TRIT_NEG) && (sym.cq == prd_pkg::TRIT_NEG))
                    || (sym.ci == prd_pkg::TRIT_ZERO)
                    || ((sym.ci == prd_pkg::TRIT_POS) && (sym.cq == prd_pkg::TRIT_POS));

   // descrambled data bits and packing
   assign key    = {scr_step[6] ^ scr_step[16], scr_step[3] ^ scr_step[8], scr_step[0]};
   assign sd     = prd_pkg::pair_to_bits(sym) ^ key;
   assign acc_or = acc_ff | ({3'd0, sd} << bcnt_ff);
   assign bsum   = {1'b0, bcnt_ff} + 3'd3;
   assign nib    = acc_or[3:0];

   // next state of one symbol
   always_comb begin
      phase_in      = phase_ff;
      scr_in        = scr_step;
      acc_in        = acc_ff;
      bcnt_in       = bcnt_ff;
      low_in        = low_ff;
      expect_low_in = expect_low_ff;
      lock_in       = lock_ff;
      match_in      = match_ff;
      err_in        = err_ff;
      clean_in      = (clean_ff <= CLEAN_LIM) ? clean_ff + 1'b1 : clean_ff;
      emit          = 1'b0;
      res_c         = '{event_kind: prd_pkg::EV_DATA, data_byte: 8'd0,
                        spare_bits: 2'd0, is_locked: lock_ff};

      unique case (phase_ff)
         PH_SSD1: phase_in = zz ? PH_SSD2 : PH_IDLE;
         PH_SSD2: begin
            if (!zz) begin
               phase_in = PH_IDLE;
            end else begin
               phase_in = PH_DATA;
               if (lock_ff) begin
                  emit               = 1'b1;
                  res_c.data_byte    = prd_pkg::PREAMBLE_BYTE;
                  res_c.spare_bits   = 2'd1;
                  acc_in             = 6'd1;
                  bcnt_in            = 2'd1;
                  low_in             = 4'd0;
                  expect_low_in      = 1'b1;
               end
            end
         end
         PH_DATA: begin
            if (zz) begin
               phase_in = PH_ESD1;
            end else if (lock_ff) begin
               if (bsum[2]) begin
                  acc_in        = {4'd0, acc_or[5:4]};
                  bcnt_in       = bsum[1:0];
                  low_in        = nib;
                  expect_low_in = !expect_low_ff;
                  if (!expect_low_ff) begin
                     emit             = 1'b1;
                     res_c.data_byte  = {nib, low_ff};
                     res_c.spare_bits = bsum[1:0];
                  end
               end else begin
                  acc_in  = acc_or;
                  bcnt_in = bsum[1:0];
               end
            end
         end
         PH_ESD1: begin
            if (zz) begin
               phase_in = PH_ESD2;
            end else begin
               phase_in = PH_IDLE;
               if (lock_ff) begin
                  emit             = 1'b1;
                  res_c.event_kind = prd_pkg::EV_ABORT;
               end
            end
         end
         PH_ESD2: begin
            phase_in = PH_IDLE;
            if (lock_ff) begin
               emit = 1'b1;
               if (sym.ci == prd_pkg::TRIT_POS && sym.cq == prd_pkg::TRIT_POS) begin
                  res_c.event_kind = prd_pkg::EV_END_GOOD;
               end else if (sym.ci == prd_pkg::TRIT_NEG && sym.cq == prd_pkg::TRIT_NEG) begin
                  res_c.event_kind = prd_pkg::EV_END_ERROR;
               end else begin
                  res_c.event_kind = prd_pkg::EV_ABORT;
               end
            end
         end
         default: begin
            if (zz) begin
               phase_in = PH_SSD1;
            end else begin
               phase_in = PH_IDLE;
               // idle alignment and lock tracking
               if (expect_bit == scr_step[0]) begin
                  if (match_ff <= MATCH_LIM) begin
                     match_in = match_ff + 1'b1;
                  end
                  if (clean_in > CLEAN_LIM) begin
                     clean_in = '0;
                     err_in   = '0;
                  end
                  if (match_in > MATCH_LIM && !lock_ff) begin
                     lock_in  = 1'b1;
                     err_in   = '0;
                     clean_in = '0;
                  end
               end else if (lock_ff) begin
                  clean_in = '0;
                  if (err_ff <= ERROR_LIM) begin
                     err_in = err_ff + 1'b1;
                  end
                  if (err_in > ERROR_LIM) begin
                     lock_in  = 1'b0;
                     match_in = '0;
                  end
               end else begin
                  match_in  = '0;
                  scr_in[0] = expect_bit;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         scr_ff        <= '0;
         acc_ff        <= '0;
         bcnt_ff       <= '0;
         low_ff        <= '0;
         expect_low_ff <= 1'b1;
         lock_ff       <= 1'b0;
         match_ff      <= '0;
         err_ff        <= '0;
         clean_ff      <= '0;
      end else if (sym_take) begin
         phase_ff      <= phase_in;
         scr_ff        <= scr_in;
         acc_ff        <= acc_in;
         bcnt_ff       <= bcnt_in;
         low_ff        <= low_in;
         expect_low_ff <= expect_low_in;
         lock_ff       <= lock_in;
         match_ff      <= match_in;
         err_ff        <= err_in;
         clean_ff      <= clean_in;
      end
   end

endmodule

`default_nettype wire

// File: src/pam3_pcs_receive_decoder_unit.sv
// PAM3 receive decoder with side-stream descrambler (100BASE-T1 style PCS)
//
// Request channel: an i/q sample pair is one transfer, taken at a rising edge
// with push high and full low. Response channel: the oldest result sits on the
// rsp_ ports while empty is low and is taken at an edge with pop high.
// Each symbol gives zero or one result: a data byte, a frame end (good or
// error esd) or an abort for a malformed esd.
// A taken symbol waits in the symbol queue. While the result queue has room,
// one symbol per cycle is sustained: the decoder state machine retires one
// queued symbol each cycle and puts its result there, shown by empty low.
// A stalled response side fills the two-entry result queue, then the
// two-entry symbol queue, and then full goes high; nothing is dropped.
// Reset (synchronous, active high) empties both queues, unlocks the
// descrambler, returns to idle and loads the register reset values.
// Registers sit on an apb port at byte address 4 * index: master_mode,
// upper_cut_i, lower_cut_i, upper_cut_q, lower_cut_q. pready is always high.
// Depends on prd_pkg, prd_slicer, prd_fifo and prd_decoder.
`default_nettype none

module pam3_pcs_receive_decoder_unit #(
   parameter int unsigned LOCK_IDLES          = 256,
   parameter int unsigned UNLOCK_ERRORS       = 16,
   parameter int unsigned ERROR_CLEAR_SYMBOLS = 1024
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request channel
   input  wire logic                                push,
   output logic                                     full,
   input  wire logic signed [prd_pkg::SAMPLE_W-1:0] req_sample_i,
   input  wire logic signed [prd_pkg::SAMPLE_W-1:0] req_sample_q,
   // response channel
   output logic                                     empty,
   input  wire logic                                pop,
   output logic [1:0]                               rsp_event_kind,
   output logic [7:0]                               rsp_data_byte,
   output logic [1:0]                               rsp_spare_bits,
   output logic                                     rsp_is_locked,
   // configuration port
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [prd_pkg::ADDR_W-1:0]          paddr,
   input  wire logic [prd_pkg::DATA_W-1:0]          pwdata,
   output logic [prd_pkg::DATA_W-1:0]               prdata,
   output logic                                     pready
);

   localparam int unsigned QUEUE_DEPTH = 2;

   prd_pkg::config_type cfg_ff, cfg_in;
   prd_pkg::symbol_type sym_in, sym_out;
   prd_pkg::result_type res, res_out;
   logic                sym_empty, sym_take, res_full, res_push;
   logic                cfg_wr;
   logic [2:0]          reg_idx;

   assign pready  = 1'b1;
   assign cfg_wr  = psel && penable && pwrite && pready;
   assign reg_idx = paddr[4:2];

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (cfg_wr) begin
         unique case (reg_idx)
            prd_pkg::REG_MASTER_MODE: cfg_in.master_mode = pwdata[0];
            prd_pkg::REG_UPPER_CUT_I: cfg_in.upper_cut_i = pwdata[prd_pkg::SAMPLE_W-1:0];
            prd_pkg::REG_LOWER_CUT_I: cfg_in.lower_cut_i = pwdata[prd_pkg::SAMPLE_W-1:0];
            prd_pkg::REG_UPPER_CUT_Q: cfg_in.upper_cut_q = pwdata[prd_pkg::SAMPLE_W-1:0];
            prd_pkg::REG_LOWER_CUT_Q: cfg_in.lower_cut_q = pwdata[prd_pkg::SAMPLE_W-1:0];
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{master_mode: 1'b1,
                    upper_cut_i: prd_pkg::CUT_UPPER_RST,
                    lower_cut_i: prd_pkg::CUT_LOWER_RST,
                    upper_cut_q: prd_pkg::CUT_UPPER_RST,
                    lower_cut_q: prd_pkg::CUT_LOWER_RST};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // register read back, cuts sign extended
   always_comb begin
      unique case (reg_idx)
         prd_pkg::REG_MASTER_MODE: prdata = {31'd0, cfg_ff.master_mode};
         prd_pkg::REG_UPPER_CUT_I: prdata = 32'(cfg_ff.upper_cut_i);
         prd_pkg::REG_LOWER_CUT_I: prdata = 32'(cfg_ff.lower_cut_i);
         prd_pkg::REG_UPPER_CUT_Q: prdata = 32'(cfg_ff.upper_cut_q);
         prd_pkg::REG_LOWER_CUT_Q: prdata = 32'(cfg_ff.lower_cut_q);
         default:                  prdata = '0;
      endcase
   end

   // front end: slicing into the symbol queue
   prd_slicer u_slicer (
      .sample_i (req_sample_i),
      .sample_q (req_sample_q),
      .cfg      (cfg_ff),
      .sym      (sym_in)
   );

   prd_fifo #(
      .item_type (prd_pkg::symbol_type),
      .DEPTH     (QUEUE_DEPTH)
   ) u_sym_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (push),
      .wr_data  (sym_in),
      .is_full  (full),
      .rd_en    (sym_take),
      .rd_data  (sym_out),
      .is_empty (sym_empty)
   );

   // back end: framing and descrambling
   prd_decoder #(
      .LOCK_IDLES          (LOCK_IDLES),
      .UNLOCK_ERRORS       (UNLOCK_ERRORS),
      .ERROR_CLEAR_SYMBOLS (ERROR_CLEAR_SYMBOLS)
   ) u_decoder (
      .clock       (clock),
      .reset       (reset),
      .master_mode (cfg_ff.master_mode),
      .sym_valid   (!sym_empty),
      .sym         (sym_out),
      .sym_take    (sym_take),
      .res_full    (res_full),
      .res_push    (res_push),
      .res         (res)
   );

   // result queue toward the response side
   prd_fifo #(
      .item_type (prd_pkg::result_type),
      .DEPTH     (QUEUE_DEPTH)
   ) u_res_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (res_push),
      .wr_data  (res),
      .is_full  (res_full),
      .rd_en    (pop),
      .rd_data  (res_out),
      .is_empty (empty)
   );

   assign rsp_event_kind = res_out.event_kind;
   assign rsp_data_byte  = res_out.data_byte;
   assign rsp_spare_bits = res_out.spare_bits;
   assign rsp_is_locked  = res_out.is_locked;

endmodule

`default_nettype wire

// File: dv/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for the pam3 receive decoder with side-stream descrambler
// depends on prd_pkg and pam3_pcs_receive_decoder_unit; holds its own decoder model

module tb;

   typedef logic signed [prd_pkg::SAMPLE_W-1:0] sample_type;
   typedef prd_pkg::trit_type level_type;

   typedef enum logic [2:0] {
      FP_IDLE = 3'd0,
      FP_SSD1 = 3'd1,
      FP_SSD2 = 3'd2,
      FP_DATA = 3'd3,
      FP_ESD1 = 3'd4,
      FP_ESD2 = 3'd5
   } frame_phase_type;

   typedef enum int {
      END_GOOD_SEQ,
      END_ERROR_SEQ,
      END_CUT_SHORT,
      END_BAD_THIRD
   } frame_end_type;

   localparam int unsigned LOCK_IDLES          = 256;
   localparam int unsigned UNLOCK_ERRORS       = 16;
   localparam int unsigned ERROR_CLEAR_SYMBOLS = 1024;
   localparam int          STALL_LIMIT         = 2000;

   logic           clock        = 1'b0;
   logic           reset        = 1'b1;
   logic           push         = 1'b0;
   logic           full;
   sample_type     req_sample_i = '0;
   sample_type     req_sample_q = '0;
   logic           empty;
   logic           pop          = 1'b0;
   logic [1:0]     rsp_event_kind;
   logic [7:0]     rsp_data_byte;
   logic [1:0]     rsp_spare_bits;
   logic           rsp_is_locked;
   logic           psel         = 1'b0;
   logic           penable      = 1'b0;
   logic           pwrite       = 1'b0;
   logic [prd_pkg::ADDR_W-1:0] paddr  = '0;
   logic [prd_pkg::DATA_W-1:0] pwdata = '0;
   logic [prd_pkg::DATA_W-1:0] prdata;
   logic           pready;

   pam3_pcs_receive_decoder_unit i_dut (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_sample_i   (req_sample_i),
      .req_sample_q   (req_sample_q),
      .empty          (empty),
      .pop            (pop),
      .rsp_event_kind (rsp_event_kind),
      .rsp_data_byte  (rsp_data_byte),
      .rsp_spare_bits (rsp_spare_bits),
      .rsp_is_locked  (rsp_is_locked),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   always #5 clock = ~clock;

   int error_count = 0;
   int sent_count  = 0;
   int burst_left  = 0;

   prd_pkg::result_type expected_events[$];

   // decoder model state
   prd_pkg::config_type cfg_q;
   frame_phase_type phase_q;
   logic [32:0]  scr_q;
   logic [5:0]   bit_acc_q;
   logic [2:0]   bit_cnt_q;
   logic [3:0]   low_nib_q;
   logic         want_low_q;
   logic         locked_q;
   logic [8:0]   match_cnt_q;
   logic [4:0]   err_cnt_q;
   logic [10:0]  clean_cnt_q;

   // ------------------------------------------------------------------
   // decoder model
   // ------------------------------------------------------------------

   task automatic reset_decoder_model();
      cfg_q.master_mode = 1'b1;
      cfg_q.upper_cut_i = prd_pkg::CUT_UPPER_RST;
      cfg_q.lower_cut_i = prd_pkg::CUT_LOWER_RST;
      cfg_q.upper_cut_q = prd_pkg::CUT_UPPER_RST;
      cfg_q.lower_cut_q = prd_pkg::CUT_LOWER_RST;
      phase_q     = FP_IDLE;
      scr_q       = '0;
      bit_acc_q   = '0;
      bit_cnt_q   = '0;
      low_nib_q   = '0;
      want_low_q  = 1'b1;
      locked_q    = 1'b0;
      match_cnt_q = '0;
      err_cnt_q   = '0;
      clean_cnt_q = '0;
   endtask

   function automatic level_type slice_level(sample_type v, sample_type upper,
                                             sample_type lower);
      if (v > upper) return prd_pkg::TRIT_POS;
      if (v < lower) return prd_pkg::TRIT_NEG;
      return prd_pkg::TRIT_ZERO;
   endfunction

   function automatic int level_value(level_type t);
      case (t)
         prd_pkg::TRIT_POS: return 1;
         prd_pkg::TRIT_NEG: return -1;
         default:           return 0;
      endcase
   endfunction

   // feedback bit that becomes the scrambler lsb on the next symbol
   function automatic logic next_scrambler_bit();
      return scr_q[32] ^ (cfg_q.master_mode ? scr_q[12] : scr_q[19]);
   endfunction

   // alignment and lock tracking on a non-zero idle symbol
   task automatic track_idle(level_type ci, level_type cq);
      logic aligned_bit;
      aligned_bit = (ci == prd_pkg::TRIT_NEG && cq == prd_pkg::TRIT_NEG) ||
                    ci == prd_pkg::TRIT_ZERO ||
                    (ci == prd_pkg::TRIT_POS && cq == prd_pkg::TRIT_POS);
      if (aligned_bit == scr_q[0]) begin
         if (match_cnt_q <= LOCK_IDLES) match_cnt_q++;
         if (clean_cnt_q > ERROR_CLEAR_SYMBOLS) begin
            clean_cnt_q = '0;
            err_cnt_q   = '0;
         end
      end else if (locked_q) begin
         clean_cnt_q = '0;
         if (err_cnt_q <= UNLOCK_ERRORS) err_cnt_q++;
         if (err_cnt_q > UNLOCK_ERRORS) begin
            locked_q    = 1'b0;
            match_cnt_q = '0;
         end
      end else begin
         match_cnt_q = '0;
         scr_q[0]    = aligned_bit;
      end
      if (match_cnt_q > LOCK_IDLES && !locked_q) begin
         locked_q    = 1'b1;
         err_cnt_q   = '0;
         clean_cnt_q = '0;
      end
   endtask

   // one accepted symbol: update the model and queue the result it causes
   task automatic advance_decoder(sample_type si, sample_type sq);
      level_type  ci, cq;
      logic       zz, emit;
      int         vi, vq;
      logic [2:0] sd, key;
      logic [3:0] nib;
      prd_pkg::result_type ev;
      ci   = slice_level(si, cfg_q.upper_cut_i, cfg_q.lower_cut_i);
      cq   = slice_level(sq, cfg_q.upper_cut_q, cfg_q.lower_cut_q);
      zz   = (ci == prd_pkg::TRIT_ZERO && cq == prd_pkg::TRIT_ZERO);
      emit = 1'b0;
      ev   = '0;
      scr_q = {scr_q[31:0], next_scrambler_bit()};
      if (clean_cnt_q <= ERROR_CLEAR_SYMBOLS) clean_cnt_q++;
      case (phase_q)
         FP_SSD1: phase_q = zz ? FP_SSD2 : FP_IDLE;
         FP_SSD2: begin
            if (!zz) begin
               phase_q = FP_IDLE;
            end else begin
               phase_q = FP_DATA;
               if (locked_q) begin
                  ev.event_kind = prd_pkg::EV_DATA;
                  ev.data_byte  = prd_pkg::PREAMBLE_BYTE;
                  ev.spare_bits = 2'd1;
                  emit       = 1'b1;
                  bit_acc_q  = 6'd1;
                  bit_cnt_q  = 3'd1;
                  low_nib_q  = '0;
                  want_low_q = 1'b1;
               end
            end
         end
         FP_DATA: begin
            if (zz) begin
               phase_q = FP_ESD1;
            end else if (locked_q) begin
               // 3b2t pair to bits, then descramble
               vi = level_value(ci);
               vq = level_value(cq);
               if (vi < 0) sd = 3'(vq + 1);
               else if (vi == 0) sd = (vq < 0) ? 3'd3 : 3'd4;
               else sd = 3'(vq + 6);
               key = {scr_q[6] ^ scr_q[16], scr_q[3] ^ scr_q[8], scr_q[0]};
               sd  = sd ^ key;
               bit_acc_q = bit_acc_q | (6'(sd) << bit_cnt_q[1:0]);
               bit_cnt_q = {1'b0, bit_cnt_q[1:0]} + 3'd3;
               if (bit_cnt_q >= 3'd4) begin
                  nib       = bit_acc_q[3:0];
                  bit_acc_q = bit_acc_q >> 4;
                  bit_cnt_q = bit_cnt_q - 3'd4;
                  if (!want_low_q) begin
                     ev.event_kind = prd_pkg::EV_DATA;
                     ev.data_byte  = {nib, low_nib_q};
                     ev.spare_bits = bit_cnt_q[1:0];
                     emit = 1'b1;
                  end
                  low_nib_q  = nib;
                  want_low_q = ~want_low_q;
               end
            end
         end
         FP_ESD1: begin
            if (zz) begin
               phase_q = FP_ESD2;
            end else begin
               phase_q = FP_IDLE;
               if (locked_q) begin
                  ev.event_kind = prd_pkg::EV_ABORT;
                  emit = 1'b1;
               end
            end
         end
         FP_ESD2: begin
            phase_q = FP_IDLE;
            if (locked_q) begin
               if (ci == prd_pkg::TRIT_POS && cq == prd_pkg::TRIT_POS)
                  ev.event_kind = prd_pkg::EV_END_GOOD;
               else if (ci == prd_pkg::TRIT_NEG && cq == prd_pkg::TRIT_NEG)
                  ev.event_kind = prd_pkg::EV_END_ERROR;
               else
                  ev.event_kind = prd_pkg::EV_ABORT;
               emit = 1'b1;
            end
         end
         default: begin
            if (zz) begin
               phase_q = FP_SSD1;
            end else begin
               phase_q = FP_IDLE;
               track_idle(ci, cq);
            end
         end
      endcase
      if (emit) begin
         ev.is_locked = locked_q;
         expected_events = {expected_events, ev};
      end
   endtask

   function automatic void apply_register(logic [2:0] idx, int value);
      case (idx)
         prd_pkg::REG_MASTER_MODE: cfg_q.master_mode = value[0];
         prd_pkg::REG_UPPER_CUT_I: cfg_q.upper_cut_i = sample_type'(value);
         prd_pkg::REG_LOWER_CUT_I: cfg_q.lower_cut_i = sample_type'(value);
         prd_pkg::REG_UPPER_CUT_Q: cfg_q.upper_cut_q = sample_type'(value);
         prd_pkg::REG_LOWER_CUT_Q: cfg_q.lower_cut_q = sample_type'(value);
         default: ;
      endcase
   endfunction

   // ------------------------------------------------------------------
   // drivers (all called at a falling edge, return at a falling edge)
   // ------------------------------------------------------------------

   // one symbol transfer, in bursts with random gaps
   task automatic send_symbol(sample_type si, sample_type sq);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 48);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      push         <= 1'b1;
      req_sample_i <= si;
      req_sample_q <= sq;
      do @(posedge clock); while (full);
      sent_count++;
      @(negedge clock);
      advance_decoder(si, sq);
   endtask

   // hold off input until every result is back and the symbol queue drained
   task automatic drain_decoder();
      push <= 1'b0;
      while (expected_events.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   // apb write then read back
   task automatic write_register(logic [2:0] idx, int value);
      logic [prd_pkg::DATA_W-1:0] rd;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= prd_pkg::DATA_W'(value);
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      apply_register(idx, value);
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rd = prdata;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
      if (idx == prd_pkg::REG_MASTER_MODE ? rd[0] !== value[0] : rd[11:0] !== value[11:0]) begin
         $error("csr readback reg %0d: expected %0h actual %0h", idx, value[11:0], rd[11:0]);
         error_count++;
      end
   endtask

   task automatic set_config(logic mode, int ui, int li, int uq, int lq);
      drain_decoder();
      write_register(prd_pkg::REG_MASTER_MODE, int'(mode));
      write_register(prd_pkg::REG_UPPER_CUT_I, ui);
      write_register(prd_pkg::REG_LOWER_CUT_I, li);
      write_register(prd_pkg::REG_UPPER_CUT_Q, uq);
      write_register(prd_pkg::REG_LOWER_CUT_Q, lq);
   endtask

   // sample value that slices to the wanted level, often right on a cut
   function automatic sample_type pick_sample(level_type want, sample_type upper,
                                              sample_type lower);
      int u, l, lo, hi;
      u = upper;
      l = lower;
      case (want)
         prd_pkg::TRIT_POS: begin
            lo = u + 1;
            hi = 2047;
         end
         prd_pkg::TRIT_NEG: begin
            lo = -2048;
            hi = (l - 1 < u) ? l - 1 : u;
         end
         default: begin
            lo = l;
            hi = u;
         end
      endcase
      if (lo > hi) return sample_type'($urandom_range(0, 4095));
      case ($urandom_range(0, 7))
         0:       return sample_type'(lo);
         1:       return sample_type'(hi);
         default: return sample_type'(lo + int'($urandom_range(0, hi - lo)));
      endcase
   endfunction

   function automatic level_type rand_level();
      case ($urandom_range(0, 2))
         0:       return prd_pkg::TRIT_NEG;
         1:       return prd_pkg::TRIT_ZERO;
         default: return prd_pkg::TRIT_POS;
      endcase
   endfunction

   task automatic send_level(level_type ci, level_type cq);
      send_symbol(pick_sample(ci, cfg_q.upper_cut_i, cfg_q.lower_cut_i),
                  pick_sample(cq, cfg_q.upper_cut_q, cfg_q.lower_cut_q));
   endtask

   task automatic send_noise();
      send_symbol(sample_type'($urandom_range(0, 4095)),
                  sample_type'($urandom_range(0, 4095)));
   endtask

   // any pair but (0,0)
   task automatic send_data_symbol();
      level_type a, b;
      do begin
         a = rand_level();
         b = rand_level();
      end while (a == prd_pkg::TRIT_ZERO && b == prd_pkg::TRIT_ZERO);
      send_level(a, b);
   endtask

   // idle symbol that agrees (or not) with the next scrambler bit
   task automatic send_idle(logic aligned);
      logic want;
      int   k;
      want = next_scrambler_bit() ^ ~aligned;
      k    = $urandom_range(0, 3);
      if (want) begin
         case (k)
            0:       send_level(prd_pkg::TRIT_NEG, prd_pkg::TRIT_NEG);
            1:       send_level(prd_pkg::TRIT_ZERO, prd_pkg::TRIT_POS);
            2:       send_level(prd_pkg::TRIT_ZERO, prd_pkg::TRIT_NEG);
            default: send_level(prd_pkg::TRIT_POS, prd_pkg::TRIT_POS);
         endcase
      end else begin
         case (k)
            0:       send_level(prd_pkg::TRIT_NEG, prd_pkg::TRIT_ZERO);
            1:       send_level(prd_pkg::TRIT_NEG, prd_pkg::TRIT_POS);
            2:       send_level(prd_pkg::TRIT_POS, prd_pkg::TRIT_NEG);
            default: send_level(prd_pkg::TRIT_POS, prd_pkg::TRIT_ZERO);
         endcase
      end
   endtask

   task automatic return_to_idle();
      while (phase_q != FP_IDLE) begin
         if (phase_q == FP_DATA) send_level(prd_pkg::TRIT_ZERO, prd_pkg::TRIT_ZERO);
         else send_idle(1'b1);
      end
   endtask

   // ssd, data symbols, then the chosen frame ending
   task automatic send_frame(int n_data, frame_end_type ending);
      level_type a, b;
      repeat (3) send_level(prd_pkg::TRIT_ZERO, prd_pkg::TRIT_ZERO);
      repeat (n_data) send_data_symbol();
      send_level(prd_pkg::TRIT_ZERO, prd_pkg::TRIT_ZERO);
      case (ending)
         END_GOOD_SEQ: begin
            send_level(prd_pkg::TRIT_ZERO, prd_pkg::TRIT_ZERO);
            send_level(prd_pkg::TRIT_POS, prd_pkg::TRIT_POS);
         end
         END_ERROR_SEQ: begin
            send_level(prd_pkg::TRIT_ZERO, prd_pkg::TRIT_ZERO);
            send_level(prd_pkg::TRIT_NEG, prd_pkg::TRIT_NEG);
         end
         END_CUT_SHORT: send_data_symbol();
         default: begin
            send_level(prd_pkg::TRIT_ZERO, prd_pkg::TRIT_ZERO);
            do begin
               a = rand_level();
               b = rand_level();
            end while (a == b && a != prd_pkg::TRIT_ZERO);
            send_level(a, b);
         end
      endcase
   endtask

   task automatic acquire_lock();
      int n;
      n = 0;
      return_to_idle();
      // a few early slips force the scrambler lsb before the clean run
      while (!locked_q) begin
         send_idle(n >= 16 || $urandom_range(0, 3) != 0);
         n++;
      end
   endtask

   function automatic int rand_frame_len();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
   endfunction

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   task automatic test_slicer_edges();
      send_symbol(sample_type'(2047), sample_type'(-2048));
      send_symbol(sample_type'(-2048), sample_type'(2047));
      send_symbol(sample_type'(820), sample_type'(820));
      send_symbol(sample_type'(-820), sample_type'(-820));
      send_symbol(sample_type'(1365), sample_type'(-1366));
      send_symbol(sample_type'(-1366), sample_type'(1365));
      // cut values themselves slice to zero: ssd start, then broken
      send_symbol(sample_type'(819), sample_type'(-819));
      send_symbol(sample_type'(-820), sample_type'(0));
      send_symbol(sample_type'(0), sample_type'(-1));
      send_symbol(sample_type'(-819), sample_type'(819));
      send_symbol(sample_type'(2047), sample_type'(0));
   endtask

   // frame seen while unlocked: tracked, nothing emitted
   task automatic test_unlocked_frames();
      return_to_idle();
      send_frame(3, END_GOOD_SEQ);
      send_frame(1, END_CUT_SHORT);
   endtask

   task automatic test_frame_endings();
      return_to_idle();
      send_frame(0, END_GOOD_SEQ);
      send_frame(8, END_GOOD_SEQ);
      send_frame(5, END_ERROR_SEQ);
      send_frame(3, END_CUT_SHORT);
      send_frame(2, END_BAD_THIRD);
      send_frame(4, END_BAD_THIRD);
   endtask

   task automatic test_loss_of_lock();
      return_to_idle();
      repeat (UNLOCK_ERRORS + 1) send_idle(1'b0);
      send_frame(4, END_GOOD_SEQ);
      acquire_lock();
   endtask

   task automatic test_register_extremes();
      // every sample slices to zero
      set_config(1'b1, 2047, -2048, 2047, -2048);
      repeat (30) send_noise();
      // crossed cuts: nothing slices to zero
      set_config(1'b0, -2048, 2047, -2048, 2047);
      repeat (30) send_noise();
   endtask

   task automatic test_random_traffic(int n_items, int slip_pct);
      int start, pick;
      start = sent_count;
      while (sent_count - start < n_items) begin
         if (!locked_q) begin
            acquire_lock();
         end else begin
            return_to_idle();
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
               send_frame(rand_frame_len(),
                          ($urandom_range(0, 9) < 7) ? END_GOOD_SEQ : END_ERROR_SEQ);
            end else if (pick < 70) begin
               send_frame(rand_frame_len(),
                          ($urandom_range(0, 1) == 0) ? END_CUT_SHORT : END_BAD_THIRD);
            end else if (pick < 84) begin
               repeat ($urandom_range(1, 8)) send_idle(1'b1);
            end else if (pick < 90) begin
               // broken ssd
               repeat ($urandom_range(1, 2))
                  send_level(prd_pkg::TRIT_ZERO, prd_pkg::TRIT_ZERO);
               send_idle(1'b1);
            end else if (pick < 90 + slip_pct) begin
               repeat ($urandom_range(1, 3)) send_idle(1'b0);
            end else begin
               repeat ($urandom_range(1, 4)) send_noise();
            end
         end
      end
   endtask

   // ------------------------------------------------------------------
   // result checking
   // ------------------------------------------------------------------

   always @(posedge clock) begin
      prd_pkg::result_type want;
      if (!reset && pop && !empty) begin
         if (expected_events.size() == 0) begin
            $error("result with nothing expected: event_kind %0d data_byte %0h",
                   rsp_event_kind, rsp_data_byte);
            error_count++;
         end else begin
            want = expected_events.pop_front();
            if (rsp_event_kind !== want.event_kind) begin
               $error("event_kind: expected %0d actual %0d", want.event_kind, rsp_event_kind);
               error_count++;
            end
            if (rsp_data_byte !== want.data_byte) begin
               $error("data_byte: expected %0h actual %0h", want.data_byte, rsp_data_byte);
               error_count++;
            end
            if (rsp_spare_bits !== want.spare_bits) begin
               $error("spare_bits: expected %0d actual %0d", want.spare_bits, rsp_spare_bits);
               error_count++;
            end
            if (rsp_is_locked !== want.is_locked) begin
               $error("is_locked: expected %0d actual %0d", want.is_locked, rsp_is_locked);
               error_count++;
            end
         end
      end
   end

   // receiver stall pattern, switching to a random mode after each run of random length
   int pop_mode  = 0;
   int pop_left  = 0;
   int pop_tick  = 0;

   always @(negedge clock) begin
      if (pop_left == 0) begin
         pop_mode = $urandom_range(0, 3);
         pop_left = $urandom_range(50, 300);
      end
      pop_left--;
      pop_tick++;
      case (pop_mode)
         0:       pop <= 1'b1;
         1:       pop <= ($urandom_range(0, 1) == 1);
         2:       pop <= (pop_tick % 4 != 3);
         default: pop <= ($urandom_range(0, 9) == 0);
      endcase
   end

   // watchdog on cycles without any transfer
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (!reset) begin
         if ((push && !full) || (pop && !empty) || (psel && penable && pready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $error("no transfer for %0d cycles", STALL_LIMIT);
            $display("simulation failed");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // run
   // ------------------------------------------------------------------

   initial begin
      reset_decoder_model();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_slicer_edges();
      test_unlocked_frames();
      acquire_lock();
      test_frame_endings();
      test_loss_of_lock();
      test_register_extremes();
      set_config(1'b0, $urandom_range(100, 1800), -int'($urandom_range(100, 1800)),
                 $urandom_range(100, 1800), -int'($urandom_range(100, 1800)));
      test_random_traffic(700, 1);
      set_config(1'b1, $urandom_range(0, 300), -int'($urandom_range(1200, 2000)),
                 $urandom_range(1200, 2000), -int'($urandom_range(0, 300)));
      test_random_traffic(350, 6);

      drain_decoder();
      repeat (10) @(negedge clock);
      if (error_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
